// ----- rtl/u8u16_pkg.sv -----
`timescale 1ns / 1ps

package u8u16_pkg;

  // Width of one UTF-16 code unit (also of the reported unit total) and of the code point accumulator.
  localparam int unsigned UnitBits  = 16;
  localparam int unsigned AccumBits = 31;

  // Surrogate prefixes and the code point limits.
  localparam logic [UnitBits-1:0] SurHigh  = 16'hD800;
  localparam logic [UnitBits-1:0] SurLow   = 16'hDC00;
  localparam logic [20:0]         PlaneOne = 21'h010000;
  localparam logic [20:0]         CodeMax  = 21'h10FFFF;

  // Depth of the result queue; an item needs two free slots to enter.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // One result beat as it leaves the block.
  typedef struct packed {
    logic [UnitBits-1:0] code_unit;
    logic                unit_valid;
    logic                string_done;
    logic                string_error;
    logic [UnitBits-1:0] unit_total;
  } result_t;

  // The results caused by one input byte: zero, one or two of them.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

endpackage

// ----- rtl/u8u16_decoder.sv -----
`timescale 1ns / 1ps

module u8u16_decoder #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_string,
  output u8u16_pkg::step_out_t  step
);
  import u8u16_pkg::*;

  localparam int unsigned TotW = (COUNT_BITS > UnitBits) ? COUNT_BITS : UnitBits;

  // Decoder state for the string in progress.
  logic [2:0]            bytes_left, bytes_left_next;
  logic [AccumBits-1:0]  code_accum, code_accum_next;
  logic                  error_seen, error_seen_next;
  logic [COUNT_BITS-1:0] unit_counter, unit_counter_next;

  logic [AccumBits-1:0]  acc_shift;
  logic [20:0]           plane_off;
  logic [1:0]            n_units;
  logic [UnitBits-1:0]   unit_a, unit_b;
  logic [COUNT_BITS-1:0] cnt_one, cnt_two;
  logic [TotW-1:0]       cnt_wide;
  logic [UnitBits-1:0]   total;
  logic                  err_final;
  result_t               res_a, res_b;

  // Continuation payload appended to the partial code point.
  assign acc_shift = {code_accum[AccumBits-7:0], data_byte[5:0]};
  assign plane_off = acc_shift[20:0] - PlaneOne;

  // Saturating unit counts after one and after two more units.
  assign cnt_one = (&unit_counter) ? unit_counter : unit_counter + 1'b1;
  assign cnt_two = (&cnt_one) ? cnt_one : cnt_one + 1'b1;

  // Decode one byte against the current state.
  always_comb begin
    bytes_left_next = bytes_left;
    code_accum_next = code_accum;
    error_seen_next = error_seen;
    n_units         = 2'd0;
    unit_a          = '0;
    unit_b          = '0;
    if (!error_seen) begin
      if (bytes_left == 3'd0) begin
        priority if (data_byte[7] == 1'b0) begin
          n_units = 2'd1;
          unit_a  = {8'd0, data_byte};
        end else if (data_byte[7:6] == 2'b10) begin
          error_seen_next = 1'b1;
        end else if (data_byte[7:5] == 3'b110) begin
          code_accum_next = {26'd0, data_byte[4:0]};
          bytes_left_next = 3'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          code_accum_next = {27'd0, data_byte[3:0]};
          bytes_left_next = 3'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          code_accum_next = {28'd0, data_byte[2:0]};
          bytes_left_next = 3'd3;
        end else if (data_byte[7:2] == 6'b111110) begin
          code_accum_next = {29'd0, data_byte[1:0]};
          bytes_left_next = 3'd4;
        end else if (data_byte[7:1] == 7'b1111110) begin
          code_accum_next = {30'd0, data_byte[0]};
          bytes_left_next = 3'd5;
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        error_seen_next = 1'b1;
        bytes_left_next = 3'd0;
        code_accum_next = '0;
      end else begin
        code_accum_next = acc_shift;
        bytes_left_next = bytes_left - 3'd1;
        if (bytes_left == 3'd1) begin
          // Last continuation: emit one unit, a surrogate pair, or flag it.
          code_accum_next = '0;
          priority if (acc_shift[AccumBits-1:16] == '0) begin
            n_units = 2'd1;
            unit_a  = acc_shift[UnitBits-1:0];
          end else if (acc_shift[AccumBits-1:21] == '0 && acc_shift[20:0] <= CodeMax) begin
            n_units = 2'd2;
            unit_a  = SurHigh | {6'd0, plane_off[19:10]};
            unit_b  = SurLow  | {6'd0, plane_off[9:0]};
          end else begin
            error_seen_next = 1'b1;
          end
        end
      end
    end
  end

  // Count after this byte's units, clipped to the width of the report.
  always_comb begin
    unique case (n_units)
      2'd0:    cnt_wide = TotW'(unit_counter);
      2'd1:    cnt_wide = TotW'(cnt_one);
      default: cnt_wide = TotW'(cnt_two);
    endcase
    total = (cnt_wide > TotW'(16'hFFFF)) ? 16'hFFFF : cnt_wide[UnitBits-1:0];
  end

  assign err_final = error_seen_next | (bytes_left_next != 3'd0);

  // Build the result beats; the last one carries the end-of-string status.
  always_comb begin
    res_a = '{code_unit: unit_a, unit_valid: (n_units != 2'd0),
              string_done: 1'b0, string_error: 1'b0, unit_total: '0};
    res_b = '{code_unit: unit_b, unit_valid: 1'b1,
              string_done: 1'b0, string_error: 1'b0, unit_total: '0};
    step.count = (n_units == 2'd0 && end_of_string) ? 2'd1 : n_units;
    if (end_of_string) begin
      if (n_units == 2'd2) begin
        res_b.string_done  = 1'b1;
        res_b.string_error = err_final;
        res_b.unit_total   = total;
      end else begin
        res_a.string_done  = 1'b1;
        res_a.string_error = err_final;
        res_a.unit_total   = total;
      end
    end
    step.first  = res_a;
    step.second = res_b;
  end

  always_comb begin
    unique case (n_units)
      2'd0:    unit_counter_next = unit_counter;
      2'd1:    unit_counter_next = cnt_one;
      default: unit_counter_next = cnt_two;
    endcase
  end

  // State update on each accepted byte; the end mark clears the string.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left   <= '0;
      code_accum   <= '0;
      error_seen   <= 1'b0;
      unit_counter <= '0;
    end else if (accept) begin
      if (end_of_string) begin
        bytes_left   <= '0;
        code_accum   <= '0;
        error_seen   <= 1'b0;
        unit_counter <= '0;
      end else begin
        bytes_left   <= bytes_left_next;
        code_accum   <= code_accum_next;
        error_seen   <= error_seen_next;
        unit_counter <= unit_counter_next;
      end
    end
  end

endmodule

// ----- rtl/u8u16_queue.sv -----
`timescale 1ns / 1ps

module u8u16_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  u8u16_pkg::step_out_t  step,
  input  logic                  pop,
  output logic                  room,
  output logic                  not_empty,
  output u8u16_pkg::result_t    head
);
  import u8u16_pkg::*;

  result_t              slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [QueuePtrW:0]   fill;
  logic [1:0]           n_push;
  logic                 do_pop;

  assign n_push    = push ? step.count : 2'd0;
  assign not_empty = (fill != '0);
  assign do_pop    = pop & not_empty;
  assign head      = slots[rd_ptr];

  // Two free slots are needed, since one byte may give a surrogate pair.
  assign room = (fill <= (QueuePtrW + 1)'(QueueDepth - 2));

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QueuePtrW'(n_push);
      rd_ptr <= rd_ptr + QueuePtrW'(do_pop);
      fill   <= fill + (QueuePtrW + 1)'(n_push) - (QueuePtrW + 1)'(do_pop);
    end
  end

  // Result storage; up to two beats are written per cycle.
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      slots[wr_ptr] <= step.first;
    end
    if (n_push == 2'd2) begin
      slots[wr_ptr + QueuePtrW'(1)] <= step.second;
    end
  end

endmodule

// ----- rtl/utf8_to_utf16_transcoder.sv -----
`timescale 1ns / 1ps

// UTF-8 to UTF-16 transcoder. Takes one UTF-8 byte per beat, with
// end_of_string on the last byte of a string, and returns UTF-16 units
// (a surrogate pair for code points from 0x10000 to 0x10FFFF). The final
// beat of each string carries string_done, the sticky string_error and the
// saturating unit_total; a string end that produces no unit returns one
// status-only beat with unit_valid low. A byte is decoded in the cycle it is
// accepted; its results are written into the result queue registers, whose
// head drives the output, and the second unit of a surrogate pair is queued
// with the first and follows it. The block takes one byte every cycle;
// in_ready drops only while the four-entry result queue has fewer than two
// free slots, which happens when the output side stalls.
module utf8_to_utf16_transcoder #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        unit_valid,
  output logic        string_done,
  output logic        string_error,
  output logic [15:0] unit_total
);
  import u8u16_pkg::*;

  logic      accept;
  step_out_t step;
  result_t   head;

  assign accept = in_valid & in_ready;

  // Byte decoder and string state.
  u8u16_decoder #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decoder (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .step          (step)
  );

  // Result queue between the decoder and the output port.
  u8u16_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .step      (step),
    .pop       (out_ready),
    .room      (in_ready),
    .not_empty (out_valid),
    .head      (head)
  );

  assign code_unit    = head.code_unit;
  assign unit_valid   = head.unit_valid;
  assign string_done  = head.string_done;
  assign string_error = head.string_error;
  assign unit_total   = head.unit_total;

endmodule

// ----- rtl/u8u16_checker.sv -----
`timescale 1ns / 1ps

module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] code_unit,
  input logic        unit_valid,
  input logic        string_done,
  input logic        string_error,
  input logic [15:0] unit_total
);

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat offered right after reset");

  // A status-only beat only appears at the end of a string.
  a_status_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !unit_valid |-> string_done && code_unit == 16'd0)
    else $error("status-only beat without string_done or with a unit");

  // Error and total are zero on beats inside a string.
  a_mid_string_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !string_done |-> !string_error && unit_total == 16'd0)
    else $error("status fields set on a beat inside a string");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_unit)
      && $stable(string_done) && $stable(unit_total))
    else $error("result beat changed while stalled");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import u8u16_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        string_done;
  logic        string_error;
  logic [15:0] unit_total;

  // Longest wait drawn before each beat, per side.
  int in_gap_max = 15;
  int out_gap_max = 15;
  int failures = 0;

  // Decoder state as the testbench tracks it.
  logic [2:0]  cont_left = '0;
  logic [30:0] code_point = '0;
  logic        string_bad = 1'b0;
  logic [15:0] units_in_string = '0;

  // UTF-16 units and string status beats still to come out of the block.
  result_t pending_units[$];

  // Text of the string being sent.
  byte_q_t text_buf;

  utf8_to_utf16_transcoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_unit    (code_unit),
    .unit_valid   (unit_valid),
    .string_done  (string_done),
    .string_error (string_error),
    .unit_total   (unit_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue one UTF-16 unit and bump the saturating per-string count.
  function automatic void emit_unit(input logic [15:0] value);
    result_t r;
    r = '0;
    r.code_unit = value;
    r.unit_valid = 1'b1;
    pending_units = {pending_units, r};
    if (units_in_string != 16'hFFFF) begin
      units_in_string++;
    end
  endfunction

  // Work out the beats that one accepted byte causes.
  task automatic decode_byte(input logic [7:0] b, input logic eos);
    int          step_units;
    logic [19:0] offset;
    result_t     r;
    step_units = 0;
    if (!string_bad) begin
      if (cont_left == 3'd0) begin
        // Lead byte or plain ASCII.
        if (b < 8'h80) begin
          emit_unit({8'h00, b});
          step_units = 1;
        end else if (b < 8'hC0) begin
          string_bad = 1'b1;
        end else if (b < 8'hE0) begin
          code_point = 31'(b[4:0]);
          cont_left = 3'd1;
        end else if (b < 8'hF0) begin
          code_point = 31'(b[3:0]);
          cont_left = 3'd2;
        end else if (b < 8'hF8) begin
          code_point = 31'(b[2:0]);
          cont_left = 3'd3;
        end else if (b < 8'hFC) begin
          code_point = 31'(b[1:0]);
          cont_left = 3'd4;
        end else if (b < 8'hFE) begin
          code_point = 31'(b[0]);
          cont_left = 3'd5;
        end else begin
          string_bad = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        // A non-continuation byte breaks the open sequence.
        string_bad = 1'b1;
        cont_left = '0;
        code_point = '0;
      end else begin
        code_point = {code_point[24:0], b[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 3'd0) begin
          if (code_point < 31'(PlaneOne)) begin
            emit_unit(code_point[15:0]);
            step_units = 1;
          end else if (code_point <= 31'(CodeMax)) begin
            offset = 20'(code_point - 31'(PlaneOne));
            emit_unit(SurHigh | 16'(offset[19:10]));
            emit_unit(SurLow | 16'(offset[9:0]));
            step_units = 2;
          end else begin
            string_bad = 1'b1;
          end
          code_point = '0;
        end
      end
    end
    // The last beat of the string carries the status.
    if (eos) begin
      if (cont_left != 3'd0) begin
        string_bad = 1'b1;
      end
      if (step_units == 0) begin
        r = '0;
      end else begin
        r = pending_units.pop_back();
      end
      r.string_done = 1'b1;
      r.string_error = string_bad;
      r.unit_total = units_in_string;
      pending_units = {pending_units, r};
      cont_left = '0;
      code_point = '0;
      string_bad = 1'b0;
      units_in_string = '0;
    end
  endtask

  // Present one byte after a random gap and hold it until accepted.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, eos);
    @(negedge clk);
  endtask

  // Send the text buffer as one string, end mark on its last byte.
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_byte(text_buf[i], i == text_buf.size() - 1);
    end
  endtask

  // Append one character of random kind and content to the text buffer.
  function automatic void append_char();
    int         pick;
    int         n_cont;
    logic [7:0] lead;
    pick = $urandom_range(0, 99);
    n_cont = 0;
    if (pick < 30) begin
      lead = 8'($urandom_range(8'h00, 8'h7F));
    end else if (pick < 50) begin
      lead = 8'($urandom_range(8'hC0, 8'hDF));
      n_cont = 1;
    end else if (pick < 65) begin
      lead = 8'($urandom_range(8'hE0, 8'hEF));
      n_cont = 2;
    end else if (pick < 82) begin
      // Mostly leads that can stay within the code space.
      lead = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hF4, 8'hF7))
                                         : 8'($urandom_range(8'hF0, 8'hF3));
      n_cont = 3;
    end else if (pick < 88) begin
      lead = 8'($urandom_range(8'hF8, 8'hFB));
      n_cont = 4;
    end else if (pick < 93) begin
      lead = 8'($urandom_range(8'hFC, 8'hFD));
      n_cont = 5;
    end else begin
      lead = 8'($urandom_range(0, 255));
    end
    text_buf = {text_buf, lead};
    repeat (n_cont) text_buf = {text_buf, 8'($urandom_range(8'h80, 8'hBF))};
  endfunction

  // Lowest and highest single-byte characters.
  task automatic test_ascii_bounds();
    text_buf = '{8'h00, 8'h7F};
    send_text();
  endtask

  // Two, three and four byte forms at their edges, surrogates passed through.
  task automatic test_valid_forms();
    text_buf = '{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'h80,
                 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
  endtask

  // Six byte lead with a small value still yields one unit.
  task automatic test_long_form();
    text_buf = '{8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h81};
    send_text();
  endtask

  // Stray continuation, bad lead, broken and truncated sequences, too large.
  task automatic test_malformed();
    text_buf = '{8'h80, 8'h41};
    send_text();
    text_buf = '{8'hFF};
    send_text();
    text_buf = '{8'hC2, 8'h41};
    send_text();
    text_buf = '{8'hE2, 8'h82};
    send_text();
    text_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_text();
  endtask

  // One string of mixed single units and surrogate pairs with no idle cycles.
  task automatic test_back_to_back();
    in_gap_max = 0;
    out_gap_max = 0;
    text_buf.delete();
    repeat (8) text_buf = {text_buf, 8'h61, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text();
    in_gap_max = 15;
    out_gap_max = 15;
  endtask

  // Random strings, mostly well formed, some corrupted or cut short.
  task automatic test_random_text();
    int bytes_sent;
    bytes_sent = 0;
    while (bytes_sent < 370) begin
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      text_buf.delete();
      repeat ($urandom_range(1, 8)) append_char();
      if ($urandom_range(0, 9) == 0) begin
        text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 9) == 0 && text_buf.size() > 1) begin
        void'(text_buf.pop_back());
      end
      bytes_sent += text_buf.size();
      send_text();
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      failures++;
    end
  endfunction

  // Output side: random stall before each beat.
  initial begin : result_sink
    int gap;
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      @(negedge clk);
    end
  end

  // Compare each accepted beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual unit %h valid %b done %b",
                 $time, code_unit, unit_valid, string_done);
        failures++;
      end else begin
        want = pending_units.pop_front();
        check_field("code_unit", want.code_unit, code_unit);
        check_field("unit_valid", 16'(want.unit_valid), 16'(unit_valid));
        check_field("string_done", 16'(want.string_done), 16'(string_done));
        check_field("string_error", 16'(want.string_error), 16'(string_error));
        check_field("unit_total", want.unit_total, unit_total);
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_ascii_bounds();
    test_valid_forms();
    test_long_form();
    test_malformed();
    test_back_to_back();
    test_random_text();
    in_valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
